[rtl/csv_field_splitter_defines.svh]
// Assertion macros for the CSV field splitter checker.
// The checker that uses them has ports named clock and reset.
`ifndef CSV_FIELD_SPLITTER_DEFINES_SVH
`define CSV_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication.
`define CSVFS_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csv_field_splitter: port check failed");

// Next-cycle implication.
`define CSVFS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csv_field_splitter: port check failed");

`endif

[rtl/csvfs_pkg.sv]
package csvfs_pkg;

   // Default value buffer depth
   localparam int DEFAULT_MAX_VALUE_CHARS = 64;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_SEPARATOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUOTE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM      = 2'd2;

   // Register reset values
   localparam logic [15:0] SEPARATOR_RESET = 16'd44;
   localparam logic [15:0] QUOTE_RESET     = 16'd34;
   localparam logic        TRIM_RESET      = 1'b1;

   // Character stored for an end of line inside quotes, and the NUL character
   localparam logic [15:0] NEWLINE_CHAR = 16'h000A;
   localparam logic [15:0] NUL_CHAR     = 16'h0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } csvfs_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take_item;   // input transaction accepted this cycle
      logic read_char;   // read buffer at the emit index
      logic load_out;    // load output register with the current result
   } csvfs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic item_closes; // offered item closes the value
      logic slot_free;   // output register free or draining this cycle
      logic at_last;     // current result is the last of the value
   } csvfs_status_type;

   // Unicode whitespace set used for trimming
   function automatic logic is_space(input logic [15:0] c);
      logic res;
      res = ((c >= 16'h0009) && (c <= 16'h000D)) ||
            (c == 16'h0020) || (c == 16'h0085) || (c == 16'h00A0) ||
            (c == 16'h1680) ||
            ((c >= 16'h2000) && (c <= 16'h200A)) ||
            (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
            (c == 16'h205F) || (c == 16'h3000);
      return res;
   endfunction

endpackage

[rtl/csvfs_ctrl.sv]
module csvfs_ctrl import csvfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  csvfs_status_type status,
   output logic             req_ready,
   output csvfs_cmd_type    cmd
);

   csvfs_state_type state_ff;
   csvfs_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.take_item = 1'b0;
      cmd.read_char = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               if (status.item_closes) state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_char = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = status.at_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/csvfs_dp.sv]
module csvfs_dp import csvfs_pkg::*; #(
   parameter int MAX_VALUE_CHARS = DEFAULT_MAX_VALUE_CHARS
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   // input payload
   input  logic                 req_cmd,
   input  logic [15:0]          req_char,
   // result channel
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic [15:0]          rsp_char,
   output logic                 rsp_char_valid,
   output logic                 rsp_value_end,
   output logic                 rsp_record_end,
   output logic                 rsp_overflow,
   // controller link
   input  csvfs_cmd_type        cmd,
   output csvfs_status_type     status
);

   localparam int IDX_W = $clog2(MAX_VALUE_CHARS);
   localparam int CNT_W = $clog2(MAX_VALUE_CHARS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VALUE_CHARS);

   // configuration registers
   logic [15:0] sep_ff,   sep_in;
   logic [15:0] quote_ff, quote_in;
   logic        trim_ff,  trim_in;

   // parse state
   logic             quoted_ff,     quoted_in;
   logic             was_quoted_ff, was_quoted_in;
   logic [15:0]      prev_ff,       prev_in;
   logic [CNT_W-1:0] len_ff,        len_in;
   logic [IDX_W-1:0] first_ff,      first_in;
   logic [IDX_W-1:0] last_ff,       last_in;
   logic             seen_ff,       seen_in;
   logic             ovf_ff,        ovf_in;

   // emit state
   logic [CNT_W-1:0] idx_ff,   idx_in;
   logic [CNT_W-1:0] end_ff,   end_in;
   logic             empty_ff, empty_in;
   logic             rec_ff,   rec_in;

   // value buffer and its read register
   logic [15:0] store_ff [MAX_VALUE_CHARS];
   logic [15:0] rd_data_ff;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_char_ff;
   logic        rsp_cvalid_ff;
   logic        rsp_vend_ff;
   logic        rsp_rend_ff;
   logic        rsp_ovf_ff;

   // item decode
   logic             hit_quote;
   logic             hit_sep;
   logic             closes;
   logic             store_req;
   logic [15:0]      store_char;
   logic             full;
   logic             do_write;
   logic [CNT_W-1:0] trim_start;
   logic [CNT_W-1:0] trim_stop;
   logic             trim_empty;
   logic             at_last;

   assign hit_quote  = !req_cmd && (req_char == quote_ff);
   assign hit_sep    = !req_cmd && !hit_quote && (req_char == sep_ff) && !quoted_ff;
   assign closes     = (req_cmd && !quoted_ff) || hit_sep;
   assign store_req  = (req_cmd && quoted_ff) ||
                       (hit_quote && !quoted_ff && (prev_ff == quote_ff)) ||
                       (!req_cmd && !hit_quote && !hit_sep);
   assign store_char = req_cmd ? NEWLINE_CHAR : req_char;
   assign full       = (len_ff >= MAX_CNT);
   assign do_write   = cmd.take_item && store_req && !full;

   // Bounds of the value to emit, trimmed when enabled and the value was not quoted
   always_comb begin
      trim_start = '0;
      trim_stop  = len_ff;
      if (trim_ff && !was_quoted_ff) begin
         if (seen_ff) begin
            trim_start = CNT_W'(first_ff);
            trim_stop  = CNT_W'(last_ff) + CNT_W'(1);
         end else begin
            trim_stop = '0;
         end
      end
      trim_empty = (trim_start >= trim_stop);
   end

   assign at_last = empty_ff || ((idx_ff + CNT_W'(1)) == end_ff);

   assign status.item_closes = closes;
   assign status.slot_free   = !rsp_valid_ff || rsp_tready;
   assign status.at_last     = at_last;

   // Configuration writes
   always_comb begin
      sep_in   = sep_ff;
      quote_in = quote_ff;
      trim_in  = trim_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SEPARATOR: sep_in   = csr_wdata;
            REG_QUOTE:     quote_in = csr_wdata;
            REG_TRIM:      trim_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Parse and emit state update
   always_comb begin
      quoted_in     = quoted_ff;
      was_quoted_in = was_quoted_ff;
      prev_in       = prev_ff;
      len_in        = len_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      seen_in       = seen_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      empty_in      = empty_ff;
      rec_in        = rec_ff;

      if (cmd.take_item) begin
         // mode and previous character
         if (req_cmd) begin
            if (!quoted_ff) prev_in = NUL_CHAR;
         end else if (hit_quote) begin
            was_quoted_in = 1'b1;
            quoted_in     = !quoted_ff;
            prev_in       = req_char;
         end else begin
            prev_in = req_char;
         end

         // buffer bookkeeping
         if (store_req) begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               if (!is_space(store_char)) begin
                  if (!seen_ff) first_in = len_ff[IDX_W-1:0];
                  last_in = len_ff[IDX_W-1:0];
                  seen_in = 1'b1;
               end
               len_in = len_ff + CNT_W'(1);
            end
         end

         // latch emit bounds when the value closes
         if (closes) begin
            idx_in   = trim_start;
            end_in   = trim_stop;
            empty_in = trim_empty;
            rec_in   = req_cmd;
         end
      end

      if (cmd.load_out) begin
         if (at_last) begin
            len_in        = '0;
            first_in      = '0;
            last_in       = '0;
            seen_in       = 1'b0;
            ovf_in        = 1'b0;
            was_quoted_in = 1'b0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   // Output valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff        <= SEPARATOR_RESET;
         quote_ff      <= QUOTE_RESET;
         trim_ff       <= TRIM_RESET;
         quoted_ff     <= 1'b0;
         was_quoted_ff <= 1'b0;
         prev_ff       <= NUL_CHAR;
         len_ff        <= '0;
         first_ff      <= '0;
         last_ff       <= '0;
         seen_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         idx_ff        <= '0;
         end_ff        <= '0;
         empty_ff      <= 1'b0;
         rec_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sep_ff        <= sep_in;
         quote_ff      <= quote_in;
         trim_ff       <= trim_in;
         quoted_ff     <= quoted_in;
         was_quoted_ff <= was_quoted_in;
         prev_ff       <= prev_in;
         len_ff        <= len_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         seen_ff       <= seen_in;
         ovf_ff        <= ovf_in;
         idx_ff        <= idx_in;
         end_ff        <= end_in;
         empty_ff      <= empty_in;
         rec_ff        <= rec_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Value buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_ff[len_ff[IDX_W-1:0]] <= store_char;
      end
      if (cmd.read_char) begin
         rd_data_ff <= store_ff[idx_ff[IDX_W-1:0]];
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_char_ff   <= empty_ff ? NUL_CHAR : rd_data_ff;
         rsp_cvalid_ff <= !empty_ff;
         rsp_vend_ff   <= at_last;
         rsp_rend_ff   <= at_last && rec_ff;
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char       = rsp_char_ff;
   assign rsp_char_valid = rsp_cvalid_ff;
   assign rsp_value_end  = rsp_vend_ff;
   assign rsp_record_end = rsp_rend_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

[rtl/csv_field_splitter.sv]
// Splits a stream of 16-bit characters into delimited values. A character or
// an end-of-line transaction that does not close a value is taken and the
// block stays ready for the next one. A separator outside quotes, or an end
// of line outside quotes, closes the value; the block then stops taking input
// and emits the buffered value one character per result, each result being a
// registered read of the value buffer, then a load of the output register that
// waits while that register is full and not taken; an empty value gives one
// result. The output register lets the next input transaction be taken while
// the final result of a value still waits for rsp_tready. Values longer than
// MAX_VALUE_CHARS keep their first characters and are flagged as overflowed on every result.
module csv_field_splitter import csvfs_pkg::*; #(
   parameter int MAX_VALUE_CHARS = DEFAULT_MAX_VALUE_CHARS
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   // input stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,  // [15:0] char_in
   input  logic                 req_tuser,  // [0] cmd
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // [15:0] char_out
   output logic                 rsp_tlast,  // value_end
   output logic [2:0]           rsp_tuser   // [0] char_valid, [1] record_end,
                                            // [2] value_overflow
);

   csvfs_cmd_type    cmd;
   csvfs_status_type status;

   csvfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   csvfs_dp #(
      .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_tuser),
      .req_char       (req_tdata),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_char       (rsp_tdata),
      .rsp_char_valid (rsp_tuser[0]),
      .rsp_value_end  (rsp_tlast),
      .rsp_record_end (rsp_tuser[1]),
      .rsp_overflow   (rsp_tuser[2]),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

[rtl/csvfs_checker.sv]
`include "csv_field_splitter_defines.svh"

module csvfs_checker import csvfs_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [15:0]          rsp_tdata,
   input logic                 rsp_tlast,
   input logic [2:0]           rsp_tuser
);

   // a stalled result stays offered with the same character
   `CSVFS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CSVFS_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // an empty value is a single result with a zero character
   `CSVFS_ASSERT_NOW(a_empty_value, rsp_tvalid && !rsp_tuser[0],
                     rsp_tlast && (rsp_tdata == 16'h0000))

   // record end only on the last result of a value
   `CSVFS_ASSERT_NOW(a_record_last, rsp_tvalid && rsp_tuser[1], rsp_tlast)

   // an offered result carries a fully defined payload
   `CSVFS_ASSERT_NOW(a_rsp_known, rsp_tvalid, !$isunknown({rsp_tdata, rsp_tlast, rsp_tuser}))

endmodule

bind csv_field_splitter csvfs_checker u_checker (.*);

[tb/sv/csv_field_splitter_tb.sv]
module csv_field_splitter_tb;
   import csvfs_pkg::*;

   // one emitted character of a field, split into its fields
   typedef struct packed {
      logic [15:0] char_out;
      logic        char_valid;
      logic        value_end;
      logic        record_end;
      logic        value_overflow;
   } field_char_type;

   // one input transaction: a text character or an end of line
   typedef struct packed {
      logic        eol;
      logic [15:0] ch;
   } text_item_type;

   // Tracks the splitter state and the characters still owed on the output
   class field_scoreboard;
      logic [15:0] sep_char   = SEPARATOR_RESET;
      logic [15:0] quote_char = QUOTE_RESET;
      logic        trim_on    = TRIM_RESET;

      logic        in_quotes  = 1'b0;
      logic        was_quoted = 1'b0;
      logic [15:0] prev_char  = NUL_CHAR;
      logic [15:0] value_buf [DEFAULT_MAX_VALUE_CHARS];
      int unsigned value_len   = 0;
      int unsigned first_solid = 0;
      int unsigned last_solid  = 0;
      logic        seen_solid  = 1'b0;
      logic        dropped     = 1'b0;

      field_char_type expected_chars[$];
      int          errors = 0;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            REG_SEPARATOR: sep_char = val;
            REG_QUOTE:     quote_char = val;
            REG_TRIM:      trim_on = val[0];
            default: ;
         endcase
      endfunction

      function bit is_blank(logic [15:0] c);
         return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
                c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
                c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
                c == 16'h3000;
      endfunction

      // buffer a character; anything past the buffer depth is lost
      function void push_char(logic [15:0] c);
         if (value_len >= DEFAULT_MAX_VALUE_CHARS) begin
            dropped = 1'b1;
            return;
         end
         value_buf[value_len] = c;
         if (!is_blank(c)) begin
            if (!seen_solid) first_solid = value_len;
            last_solid = value_len;
            seen_solid = 1'b1;
         end
         value_len++;
      endfunction

      // close the field: queue its characters (trimmed if allowed), then clear
      function void close_value(bit rec);
         int unsigned lo, hi, k;
         field_char_type r;
         lo = 0;
         hi = value_len;
         if (trim_on && !was_quoted) begin
            if (seen_solid) begin
               lo = first_solid;
               hi = last_solid + 1;
            end else begin
               hi = 0;
            end
         end
         if (lo >= hi) begin
            r = field_char_type'{NUL_CHAR, 1'b0, 1'b1, rec, dropped};
            expected_chars.push_back(r);
         end else begin
            for (k = lo; k < hi; k++) begin
               r.char_out       = value_buf[k];
               r.char_valid     = 1'b1;
               r.value_end      = (k + 1 == hi);
               r.record_end     = r.value_end && rec;
               r.value_overflow = dropped;
               expected_chars.push_back(r);
            end
         end
         value_len   = 0;
         first_solid = 0;
         last_solid  = 0;
         seen_solid  = 1'b0;
         dropped     = 1'b0;
         was_quoted  = 1'b0;
      endfunction

      // called for every accepted input transaction
      function void accept_item(text_item_type it);
         if (it.eol) begin
            // line break inside quotes becomes part of the field
            if (in_quotes) begin
               push_char(NEWLINE_CHAR);
               return;
            end
            prev_char = NUL_CHAR;
            close_value(1'b1);
            return;
         end
         // quote is tested ahead of the separator
         if (it.ch == quote_char) begin
            was_quoted = 1'b1;
            if (in_quotes) begin
               in_quotes = 1'b0;
            end else begin
               if (prev_char == quote_char) push_char(it.ch);
               in_quotes = 1'b1;
            end
            prev_char = it.ch;
            return;
         end
         if (it.ch == sep_char && !in_quotes) begin
            prev_char = it.ch;
            close_value(1'b0);
            return;
         end
         push_char(it.ch);
         prev_char = it.ch;
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("ERROR: %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
         errors++;
      endtask

      // called for every accepted result transaction
      task check_char(field_char_type got);
         field_char_type want;
         if (expected_chars.size() == 0) begin
            report("result with nothing pending, char_out", got.char_out, 0);
            return;
         end
         want = expected_chars.pop_front();
         if (got.char_out !== want.char_out)
            report("char_out", got.char_out, want.char_out);
         if (got.char_valid !== want.char_valid)
            report("char_valid", got.char_valid, want.char_valid);
         if (got.value_end !== want.value_end)
            report("value_end", got.value_end, want.value_end);
         if (got.record_end !== want.record_end)
            report("record_end", got.record_end, want.record_end);
         if (got.value_overflow !== want.value_overflow)
            report("value_overflow", got.value_overflow, want.value_overflow);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;  // [15:0] char_in
   logic                 req_tuser = 1'b0; // [0] cmd
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;       // [15:0] char_out
   logic                 rsp_tlast;
   logic [2:0]           rsp_tuser;       // [0] char_valid, [1] record_end, [2] value_overflow

   field_scoreboard sb = new;

   logic [15:0] sep_now   = SEPARATOR_RESET;
   logic [15:0] quote_now = QUOTE_RESET;
   text_item_type  pending_items[$];
   bit          hold_rsp   = 1'b0;
   bit          rx_holding = 1'b0;

   csv_field_splitter u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshakes hang
   initial begin
      #50000000;
      $display("Test completed with failures");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic logic [15:0] pick_blank();
      case ($urandom_range(0, 7))
         0: return 16'h0020;
         1: return 16'h0009;
         2: return 16'h000D;
         3: return 16'h00A0;
         4: return 16'h3000;
         5: return 16'($urandom_range(16'h2000, 16'h200A));
         6: begin
            case ($urandom_range(0, 5))
               0: return 16'h0085;
               1: return 16'h1680;
               2: return 16'h2028;
               3: return 16'h2029;
               4: return 16'h202F;
               default: return 16'h205F;
            endcase
         end
         default: return 16'($urandom_range(16'h000A, 16'h000C));
      endcase
   endfunction

   function automatic logic [15:0] pick_text();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 16'($urandom_range(16'h0061, 16'h007A));
      if (r < 12) return 16'($urandom_range(16'h0030, 16'h0039));
      if (r < 15) return pick_blank();
      return rnd16();
   endfunction

   task automatic queue_item(input logic eol, input logic [15:0] ch);
      pending_items.push_back(text_item_type'{eol, ch});
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) queue_item(1'b0, {8'h00, s[i]});
   endtask

   // one field followed by a separator or a line end
   task automatic add_value(input bit closes_line, input int kind);
      int n, i, r;
      if (kind < 10) begin
         // plain field with optional padding
         n = $urandom_range(0, 2);
         for (i = 0; i < n; i++) queue_item(1'b0, pick_blank());
         n = $urandom_range(0, 6);
         for (i = 0; i < n; i++) queue_item(1'b0, pick_text());
         n = $urandom_range(0, 2);
         for (i = 0; i < n; i++) queue_item(1'b0, pick_blank());
      end else if (kind < 16) begin
         // quoted field with doubled quotes, separators and line breaks inside
         if ($urandom_range(0, 1)) queue_item(1'b0, pick_blank());
         queue_item(1'b0, quote_now);
         n = $urandom_range(0, 6);
         for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
               queue_item(1'b0, quote_now);
               queue_item(1'b0, quote_now);
            end else if (r == 1) begin
               queue_item(1'b0, sep_now);
            end else if (r == 2) begin
               queue_item(1'b1, rnd16());
            end else begin
               queue_item(1'b0, pick_text());
            end
         end
         queue_item(1'b0, quote_now);
         if ($urandom_range(0, 3) == 0) queue_item(1'b0, pick_text());
      end else if (kind == 16) begin
         // long field, usually past the buffer depth
         n = $urandom_range(62, 72);
         for (i = 0; i < n; i++) queue_item(1'b0, pick_text());
      end else begin
         // stray quotes, separators and line ends
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
               0: queue_item(1'b0, quote_now);
               1: queue_item(1'b0, sep_now);
               2: queue_item(1'b1, rnd16());
               default: queue_item(1'b0, rnd16());
            endcase
         end
      end
      if (closes_line) queue_item(1'b1, rnd16());
      else queue_item(1'b0, sep_now);
   endtask

   task automatic add_record();
      int nv, i;
      nv = $urandom_range(1, 4);
      for (i = 0; i < nv; i++) add_value(i == nv - 1, $urandom_range(0, 19));
   endtask

   // offer one transaction and wait for it to be taken
   task automatic send_item(input text_item_type it);
      int gap;
      gap = rx_holding ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.ch;
      req_tuser  <= it.eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.accept_item(it);
   endtask

   task automatic drive_pending();
      while (pending_items.size() > 0) send_item(pending_items.pop_front());
   endtask

   // block is idle here; all three registers written back to back
   task automatic set_regs(input logic [15:0] sep, input logic [15:0] quo,
                           input logic [15:0] trim_word);
      csr_we    <= 1'b1;
      csr_index <= REG_SEPARATOR;
      csr_wdata <= sep;
      @(posedge clock);
      csr_index <= REG_QUOTE;
      csr_wdata <= quo;
      @(posedge clock);
      csr_index <= REG_TRIM;
      csr_wdata <= trim_word;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(REG_SEPARATOR, sep);
      sb.set_reg(REG_QUOTE, quo);
      sb.set_reg(REG_TRIM, trim_word);
      sep_now   = sep;
      quote_now = quo;
   endtask

   // leave quotes, end the line, then let the output drain
   task automatic finish_phase();
      if (sb.in_quotes) queue_item(1'b0, quote_now);
      queue_item(1'b1, rnd16());
      drive_pending();
      req_tvalid <= 1'b0;
      while (sb.expected_chars.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] sep, input logic [15:0] quo, input bit trim,
                            input int n_items, input bit hold);
      logic [15:0] trim_word;
      // upper bits of the trim write are don't-care
      trim_word = rnd16() & 16'hFFFE;
      trim_word[0] = trim;
      set_regs(sep, quo, trim_word);
      if (hold) begin
         add_value(1'b1, 16);
         add_value(1'b1, 16);
      end
      while (pending_items.size() < n_items) add_record();
      hold_rsp = hold;
      drive_pending();
      finish_phase();
   endtask

   // result side: check each transaction, random back-pressure
   initial begin : rsp_side
      int stall_left, run_left;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_char(field_char_type'{rsp_tdata, rsp_tuser[0], rsp_tlast,
                                           rsp_tuser[1], rsp_tuser[2]});
         // long hold-off so the block fills and stalls its input
         if (hold_rsp) begin
            hold_rsp   = 1'b0;
            rx_holding = 1'b1;
            stall_left = 400;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rx_holding = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            rx_holding = 1'b0;
            stall_left = gap_len();
            run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // default characters: padding, empty field, doubled quote, quoted
      // separator and line break, all-blank field, extreme characters
      queue_text(" a ,");
      queue_text(",");
      queue_text("\"\"\"x\",");
      queue_text("\",");
      queue_item(1'b1, 16'h0000);
      queue_text("y\"");
      queue_item(1'b1, 16'hFFFF);
      queue_item(1'b0, 16'h3000);
      queue_item(1'b0, 16'h0009);
      queue_text(",");
      queue_item(1'b0, 16'hFFFF);
      queue_item(1'b0, 16'h0000);
      queue_item(1'b1, 16'hFFFF);
      run_phase(SEPARATOR_RESET, QUOTE_RESET, TRIM_RESET, pending_items.size() + 25, 1'b0);

      // quote is NUL: a NUL opening a line is kept as a literal
      queue_item(1'b0, NUL_CHAR);
      queue_item(1'b0, 16'h0078);
      queue_item(1'b0, NUL_CHAR);
      queue_item(1'b1, 16'h5555);
      run_phase(16'hFFFF, NUL_CHAR, 1'b0, pending_items.size() + 20, 1'b0);

      run_phase(NUL_CHAR, 16'hFFFF, 1'b1, 25, 1'b0);

      // semicolon and apostrophe, with the output held off for a while
      run_phase(16'h003B, 16'h0027, 1'b1, 80, 1'b1);

      // separator equal to quote: the quote meaning wins
      run_phase(16'h007C, 16'h007C, 1'b0, 15, 1'b0);

      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
